// File: rtl/core/kvt_pkg.sv
// Shared types and constants for the key/value string tokenizer core.
// Depends on nothing; used by kvt_parser, kvt_out_buf and the top level.
`default_nettype none

package kvt_pkg;

   // Result kinds, as carried on rsp_tuser.
   typedef enum logic [2:0] {
      KIND_KEY_BYTE = 3'd0,
      KIND_KEY_DROP = 3'd1,
      KIND_KEY_DONE = 3'd2,
      KIND_VAL_BYTE = 3'd3,
      KIND_VAL_DONE = 3'd4,
      KIND_END      = 3'd5
   } kind_type;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_KEY_BARE   = 3'd1,
      PH_KEY_QUOTED = 3'd2,
      PH_AFTER_KEY  = 3'd3,
      PH_VAL_START  = 3'd4,
      PH_VAL_BARE   = 3'd5,
      PH_VAL_QUOTED = 3'd6
   } phase_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;

   // One result item.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // The results caused by one input byte, first one in res0.
   typedef struct packed {
      result_type res0;
      result_type res1;
      logic [1:0] count;
   } result_pair_type;

endpackage

`default_nettype wire

// File: rtl/core/kvt_parser.sv
// Parser state and per-byte decode for the key/value string tokenizer.
// Depends on kvt_pkg.
`default_nettype none

module kvt_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire logic [7:0]               char_in,
   output kvt_pkg::result_pair_type      pair
);

   kvt_pkg::phase_type phase_ff, phase_in;
   logic               quote_dq_ff, quote_dq_in;

   logic is_space, is_quote, closes, is_nul, is_eq, char_dq;

   always_comb begin
      is_nul   = (char_in == kvt_pkg::CHAR_NUL);
      is_eq    = (char_in == kvt_pkg::CHAR_EQUALS);
      char_dq  = (char_in == kvt_pkg::CHAR_DQUOTE);
      is_space = (char_in == kvt_pkg::CHAR_SPACE) || (char_in == kvt_pkg::CHAR_TAB) ||
                 (char_in == kvt_pkg::CHAR_LF) || (char_in == kvt_pkg::CHAR_CR);
      is_quote = char_dq || (char_in == kvt_pkg::CHAR_SQUOTE);
      closes   = quote_dq_ff ? char_dq : (char_in == kvt_pkg::CHAR_SQUOTE);
   end

   kvt_pkg::kind_type k0, k1;
   logic [7:0]        d0, d1;
   logic [1:0]        n;

   always_comb begin
      phase_in    = phase_ff;
      quote_dq_in = quote_dq_ff;
      k0          = kvt_pkg::KIND_END;
      k1          = kvt_pkg::KIND_END;
      d0          = 8'd0;
      d1          = 8'd0;
      n           = 2'd0;
      case (phase_ff)
         kvt_pkg::PH_KEY_BARE, kvt_pkg::PH_KEY_QUOTED: begin
            if (is_nul) begin
               k0 = kvt_pkg::KIND_KEY_DROP;
               n  = 2'd2;
               phase_in    = kvt_pkg::PH_IDLE;
               quote_dq_in = 1'b0;
            end else if (phase_ff == kvt_pkg::PH_KEY_QUOTED) begin
               if (closes) begin
                  phase_in = kvt_pkg::PH_AFTER_KEY;
               end else begin
                  k0 = kvt_pkg::KIND_KEY_BYTE;
                  d0 = char_in;
                  n  = 2'd1;
               end
            end else if (is_space) begin
               phase_in = kvt_pkg::PH_AFTER_KEY;
            end else if (is_eq) begin
               k0 = kvt_pkg::KIND_KEY_DONE;
               n  = 2'd1;
               phase_in = kvt_pkg::PH_VAL_START;
            end else if (is_quote) begin
               k0 = kvt_pkg::KIND_KEY_DROP;
               n  = 2'd1;
               quote_dq_in = char_dq;
               phase_in    = kvt_pkg::PH_KEY_QUOTED;
            end else begin
               k0 = kvt_pkg::KIND_KEY_BYTE;
               d0 = char_in;
               n  = 2'd1;
            end
         end
         kvt_pkg::PH_AFTER_KEY: begin
            if (is_nul) begin
               k0 = kvt_pkg::KIND_KEY_DROP;
               n  = 2'd2;
               phase_in    = kvt_pkg::PH_IDLE;
               quote_dq_in = 1'b0;
            end else if (is_space) begin
               phase_in = phase_ff;
            end else if (is_eq) begin
               k0 = kvt_pkg::KIND_KEY_DONE;
               n  = 2'd1;
               phase_in = kvt_pkg::PH_VAL_START;
            end else if (is_quote) begin
               k0 = kvt_pkg::KIND_KEY_DROP;
               n  = 2'd1;
               quote_dq_in = char_dq;
               phase_in    = kvt_pkg::PH_KEY_QUOTED;
            end else begin
               k0 = kvt_pkg::KIND_KEY_DROP;
               k1 = kvt_pkg::KIND_KEY_BYTE;
               d1 = char_in;
               n  = 2'd2;
               phase_in = kvt_pkg::PH_KEY_BARE;
            end
         end
         kvt_pkg::PH_VAL_START, kvt_pkg::PH_VAL_BARE, kvt_pkg::PH_VAL_QUOTED: begin
            if (is_nul) begin
               k0 = kvt_pkg::KIND_VAL_DONE;
               n  = 2'd2;
               phase_in    = kvt_pkg::PH_IDLE;
               quote_dq_in = 1'b0;
            end else if (phase_ff == kvt_pkg::PH_VAL_QUOTED) begin
               if (closes) begin
                  k0 = kvt_pkg::KIND_VAL_DONE;
                  n  = 2'd1;
                  phase_in = kvt_pkg::PH_IDLE;
               end else begin
                  k0 = kvt_pkg::KIND_VAL_BYTE;
                  d0 = char_in;
                  n  = 2'd1;
               end
            end else if (is_space) begin
               // Whitespace is skipped before a value and ends a bare one.
               if (phase_ff == kvt_pkg::PH_VAL_BARE) begin
                  k0 = kvt_pkg::KIND_VAL_DONE;
                  n  = 2'd1;
                  phase_in = kvt_pkg::PH_IDLE;
               end
            end else if (is_eq) begin
               // The value closes and an empty key is confirmed at once.
               k0 = kvt_pkg::KIND_VAL_DONE;
               k1 = kvt_pkg::KIND_KEY_DONE;
               n  = 2'd2;
               phase_in = kvt_pkg::PH_VAL_START;
            end else if (is_quote) begin
               quote_dq_in = char_dq;
               if (phase_ff == kvt_pkg::PH_VAL_BARE) begin
                  k0 = kvt_pkg::KIND_VAL_DONE;
                  n  = 2'd1;
                  phase_in = kvt_pkg::PH_KEY_QUOTED;
               end else begin
                  phase_in = kvt_pkg::PH_VAL_QUOTED;
               end
            end else begin
               k0 = kvt_pkg::KIND_VAL_BYTE;
               d0 = char_in;
               n  = 2'd1;
               phase_in = kvt_pkg::PH_VAL_BARE;
            end
         end
         default: begin
            phase_in = kvt_pkg::PH_IDLE;
            if (is_nul) begin
               n = 2'd1;
               quote_dq_in = 1'b0;
            end else if (is_space) begin
               phase_in = kvt_pkg::PH_IDLE;
            end else if (is_eq) begin
               k0 = kvt_pkg::KIND_KEY_DONE;
               n  = 2'd1;
               phase_in = kvt_pkg::PH_VAL_START;
            end else if (is_quote) begin
               quote_dq_in = char_dq;
               phase_in    = kvt_pkg::PH_KEY_QUOTED;
            end else begin
               k0 = kvt_pkg::KIND_KEY_BYTE;
               d0 = char_in;
               n  = 2'd1;
               phase_in = kvt_pkg::PH_KEY_BARE;
            end
         end
      endcase

      pair.res0.kind = k0;
      pair.res0.data = d0;
      pair.res0.last = (n == 2'd1);
      pair.res1.kind = k1;
      pair.res1.data = d1;
      pair.res1.last = 1'b1;
      pair.count     = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= kvt_pkg::PH_IDLE;
         quote_dq_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         quote_dq_ff <= quote_dq_in;
      end
   end

`ifndef SYNTHESIS
   // An end-of-string result always leaves the parser idle with the quote flag clear.
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && (pair.count != 2'd0) &&
      ((pair.res0.kind == kvt_pkg::KIND_END) || (pair.count == 2'd2 &&
        pair.res1.kind == kvt_pkg::KIND_END))
      |=> (phase_ff == kvt_pkg::PH_IDLE) && !quote_dq_ff)
      else $error("kvt_parser: end of string did not return to idle");

   // A zero byte always yields an end-of-string result as the final one.
   a_nul_ends: assert property (@(posedge clock) disable iff (reset)
      fire && is_nul |-> ((pair.count == 2'd1 && pair.res0.kind == kvt_pkg::KIND_END) ||
                          (pair.count == 2'd2 && pair.res1.kind == kvt_pkg::KIND_END)))
      else $error("kvt_parser: zero byte without end-of-string result");
`endif

endmodule

`default_nettype wire

// File: rtl/core/kvt_out_buf.sv
// Two-slot result buffer for the key/value string tokenizer; slot 0 drives the
// result channel. Depends on kvt_pkg.
`default_nettype none

module kvt_out_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire kvt_pkg::result_pair_type pair,
   output logic                          room,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output kvt_pkg::result_type           out_res
);

   kvt_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                pop;
   logic [1:0]          cnt_after;
   logic [2:0]          cnt_sum;

   always_comb begin
      pop       = (cnt_ff != 2'd0) && out_ready;
      cnt_after = cnt_ff - {1'b0, pop};
      cnt_sum   = {1'b0, cnt_after} + {1'b0, pair.count};
      room      = (cnt_sum <= 3'd2);

      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_after;
      if (push) begin
         // With both slots still full only a byte without results can be
         // pushed, and then neither slot may change.
         if (cnt_after == 2'd0) begin
            slot0_in = pair.res0;
            slot1_in = pair.res1;
         end else if (cnt_after == 2'd1) begin
            slot1_in = pair.res0;
         end
         cnt_in = cnt_sum[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_res   = slot0_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("kvt_out_buf: occupancy beyond two slots");

   // Nothing taken and nothing produced leaves the occupancy as it was.
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !pop && (!push || pair.count == 2'd0) |=> $stable(cnt_ff))
      else $error("kvt_out_buf: occupancy changed without traffic");
`endif

endmodule

`default_nettype wire

// File: rtl/core/key_value_init_string_tokenizer_core.sv
// Top level of the key/value string tokenizer: input register, parser and
// result buffer. Depends on kvt_pkg, kvt_parser and kvt_out_buf.
//
//   Channel   Direction  Payload                           Handshake
//   req_*     in         tdata[7:0] = char_in              tvalid / tready
//   rsp_*     out        tuser[2:0] = kind,                tvalid / tready
//                        tdata[7:0] = data_byte,
//                        tlast      = run_last
//
// Each byte is taken into an input register and decoded there, provided the
// two-slot result buffer can hold every result it causes. Bytes with one
// result or none flow back to back while rsp_tready is high; bytes with two
// results each go no faster than the result side takes them, one item per
// cycle while rsp_tready is high, so a long run of such bytes is paced by the
// result port. Synchronous reset returns the parser to idle between elements
// and empties the input register and the buffer. A stall on rsp_tready
// backs up into the buffer and then the input register, holding req_tready low.
`default_nettype none

module key_value_init_string_tokenizer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_in
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic [2:0]      rsp_tuser,   // [2:0] kind
   output logic            rsp_tlast    // run_last
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       fire, room, req_acc;

   kvt_pkg::result_pair_type pair;
   kvt_pkg::result_type      head;

   // The held byte is decoded when the buffer has space for all its results.
   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_char_in = in_char_ff;
      if (req_acc) begin
         in_vld_in  = 1'b1;
         in_char_in = req_tdata;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   kvt_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .char_in (in_char_ff),
      .pair    (pair)
   );

   kvt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .pair      (pair),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = head.data;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

`ifndef SYNTHESIS
   // A byte waiting in the input register is never overwritten before decode.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |-> !req_tready)
      else $error("tokenizer core: held byte could be overwritten");
`endif

endmodule

`default_nettype wire

// File: test/key_value_init_string_tokenizer_core_tb.sv
// Self-checking testbench for key_value_init_string_tokenizer_core.
// Drives byte strings on the req_ stream, predicts the token results in a scoreboard
// class and checks every rsp_ item against them. Depends on kvt_pkg and the core.
`default_nettype none

module key_value_init_string_tokenizer_core_tb;
   import kvt_pkg::*;

   // Scoreboard: keeps its own copy of the parser phase and the open-quote kind,
   // works out the tokens that each accepted byte causes and checks the results
   // in order against them.
   class token_scoreboard;
      phase_type  phase;
      bit         quote_double;
      result_type expected_tokens[$];
      result_type byte_tokens[$];
      int         errors;
      int         mismatches;

      function new();
         phase        = PH_IDLE;
         quote_double = 1'b0;
         errors       = 0;
         mismatches   = 0;
      endfunction

      static function bit is_blank(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
      endfunction

      static function bit is_quote(logic [7:0] c);
         return c == CHAR_SQUOTE || c == CHAR_DQUOTE;
      endfunction

      function void add_token(kind_type k, logic [7:0] d);
         result_type r;
         r.kind = k;
         r.data = d;
         r.last = 1'b0;
         byte_tokens.push_back(r);
      endfunction

      function bit closes(logic [7:0] c);
         return quote_double ? (c == CHAR_DQUOTE) : (c == CHAR_SQUOTE);
      endfunction

      function void open_quote(logic [7:0] c, phase_type next_phase);
         quote_double = (c == CHAR_DQUOTE);
         phase        = next_phase;
      endfunction

      function void end_of_string();
         add_token(KIND_END, 8'h00);
         phase        = PH_IDLE;
         quote_double = 1'b0;
      endfunction

      // A new key begins at c, which is neither blank, '=' nor zero.
      function void begin_key(logic [7:0] c);
         if (is_quote(c)) begin
            open_quote(c, PH_KEY_QUOTED);
         end else begin
            add_token(KIND_KEY_BYTE, c);
            phase = PH_KEY_BARE;
         end
      endfunction

      function void predict_tokens(logic [7:0] c);
         byte_tokens.delete();
         case (phase)
            PH_KEY_BARE: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_KEY_DROP, 8'h00);
                  end_of_string();
               end else if (is_blank(c)) begin
                  phase = PH_AFTER_KEY;
               end else if (c == CHAR_EQUALS) begin
                  add_token(KIND_KEY_DONE, 8'h00);
                  phase = PH_VAL_START;
               end else if (is_quote(c)) begin
                  add_token(KIND_KEY_DROP, 8'h00);
                  open_quote(c, PH_KEY_QUOTED);
               end else begin
                  add_token(KIND_KEY_BYTE, c);
               end
            end
            PH_KEY_QUOTED: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_KEY_DROP, 8'h00);
                  end_of_string();
               end else if (closes(c)) begin
                  phase = PH_AFTER_KEY;
               end else begin
                  add_token(KIND_KEY_BYTE, c);
               end
            end
            PH_AFTER_KEY: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_KEY_DROP, 8'h00);
                  end_of_string();
               end else if (c == CHAR_EQUALS) begin
                  add_token(KIND_KEY_DONE, 8'h00);
                  phase = PH_VAL_START;
               end else if (!is_blank(c)) begin
                  add_token(KIND_KEY_DROP, 8'h00);
                  begin_key(c);
               end
            end
            PH_VAL_START: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  end_of_string();
               end else if (c == CHAR_EQUALS) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  add_token(KIND_KEY_DONE, 8'h00);
               end else if (is_quote(c)) begin
                  open_quote(c, PH_VAL_QUOTED);
               end else if (!is_blank(c)) begin
                  add_token(KIND_VAL_BYTE, c);
                  phase = PH_VAL_BARE;
               end
            end
            PH_VAL_BARE: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  end_of_string();
               end else if (is_blank(c)) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  phase = PH_IDLE;
               end else if (c == CHAR_EQUALS) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  add_token(KIND_KEY_DONE, 8'h00);
                  phase = PH_VAL_START;
               end else if (is_quote(c)) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  open_quote(c, PH_KEY_QUOTED);
               end else begin
                  add_token(KIND_VAL_BYTE, c);
               end
            end
            PH_VAL_QUOTED: begin
               if (c == CHAR_NUL) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  end_of_string();
               end else if (closes(c)) begin
                  add_token(KIND_VAL_DONE, 8'h00);
                  phase = PH_IDLE;
               end else begin
                  add_token(KIND_VAL_BYTE, c);
               end
            end
            default: begin
               phase = PH_IDLE;
               if (c == CHAR_NUL) begin
                  end_of_string();
               end else if (c == CHAR_EQUALS) begin
                  add_token(KIND_KEY_DONE, 8'h00);
                  phase = PH_VAL_START;
               end else if (!is_blank(c)) begin
                  begin_key(c);
               end
            end
         endcase
         if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
         foreach (byte_tokens[i])
            expected_tokens.push_back(byte_tokens[i]);
      endfunction

      function void check_token(logic [2:0] kind, logic [7:0] data, logic last);
         result_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            if (mismatches < 10)
               $display("unexpected result: kind %0d data %02h last %0b", kind, data, last);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         if (want.kind !== kind || want.data !== data || want.last !== last) begin
            errors++;
            if (mismatches < 10)
               $display("mismatch: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
                        want.kind, want.data, want.last, kind, data, last);
            mismatches++;
         end
      endfunction
   endclass

   localparam int QUIET_LIMIT = 2000;   // cycles with no item accepted on either side
   localparam int TOTAL_CHARS = 900;
   localparam int CALM_FROM   = 760;    // from here on neither side idles

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   token_scoreboard scoreboard;
   bit              idle_enable;
   int              chars_sent;
   logic [7:0]      directed_chars[$];
   logic [7:0]      string_bytes[$];

   key_value_init_string_tokenizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one byte from a falling edge and holds it until the rising edge at
   // which the block takes it. Before the byte there may be a short gap, which
   // leaves req_tvalid low. The call returns at the following falling edge with
   // req_tvalid still high, so back-to-back bytes never see it drop.
   task automatic send_char(logic [7:0] c);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      scoreboard.predict_tokens(c);
      chars_sent++;
      @(negedge clock);
   endtask

   // A byte that may appear in a bare key or value.
   function automatic logic [7:0] bare_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (token_scoreboard::is_blank(c) || token_scoreboard::is_quote(c) || c == CHAR_EQUALS);
      return c;
   endfunction

   // A byte inside a quoted element: anything except zero and the closing quote.
   // A space, '=' and the other quote are favoured, since they are literal there.
   function automatic logic [7:0] quoted_char(logic [7:0] quote);
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 2))
            0:       c = CHAR_SPACE;
            1:       c = CHAR_EQUALS;
            default: c = (quote == CHAR_DQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE;
         endcase
         return c;
      end
      do c = 8'($urandom_range(1, 255));
      while (c == quote);
      return c;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_LF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] quote_char();
      return $urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE;
   endfunction

   // Noise leans on the bytes that steer the parser, zero among them.
   function automatic logic [7:0] noise_char();
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0:       return CHAR_NUL;
         1:       return CHAR_EQUALS;
         2:       return quote_char();
         default: return blank_char();
      endcase
   endfunction

   // Appends a key or a value: empty, bare, or quoted, the quote sometimes left
   // open so that the zero byte ends it. Returns 1 when the string is already over.
   function automatic bit add_element(bit allow_empty);
      logic [7:0] qc;
      int         pick;
      pick = $urandom_range(allow_empty ? 0 : 1, 7);
      if (pick == 0)
         return 1'b0;
      if (pick <= 4) begin
         repeat ($urandom_range(1, 5)) string_bytes.push_back(bare_char());
         return 1'b0;
      end
      qc = quote_char();
      string_bytes.push_back(qc);
      repeat ($urandom_range(0, 4)) string_bytes.push_back(quoted_char(qc));
      if ($urandom_range(0, 9) == 0) begin
         string_bytes.push_back(CHAR_NUL);
         return 1'b1;
      end
      string_bytes.push_back(qc);
      return 1'b0;
   endfunction

   // Builds one zero-terminated string. Most are well formed key=value lists
   // with random content; some miss the '=', run straight into the next key or
   // leave a quote open, and one in eight is plain noise.
   function automatic void build_string();
      int n_pairs;
      string_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 12)) string_bytes.push_back(noise_char());
         string_bytes.push_back(CHAR_NUL);
         return;
      end
      n_pairs = $urandom_range(0, 4);
      for (int i = 0; i < n_pairs; i++) begin
         if ($urandom_range(0, 2) == 0)
            string_bytes.push_back(blank_char());
         if (add_element(1'b1))
            return;
         if ($urandom_range(0, 3) == 0)
            string_bytes.push_back(blank_char());
         if ($urandom_range(0, 7) != 0) begin
            string_bytes.push_back(CHAR_EQUALS);
            if ($urandom_range(0, 3) == 0)
               string_bytes.push_back(blank_char());
            if (add_element(1'b1))
               return;
         end
         // Without a separator a bare value runs into whatever comes next.
         if ($urandom_range(0, 5) != 0)
            string_bytes.push_back(blank_char());
      end
      string_bytes.push_back(CHAR_NUL);
   endfunction

   // Result side: rsp_tready changes only at falling edges and drops low at
   // random while idling is allowed.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every result item accepted at a rising edge goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_token(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // A run that stops moving ends here rather than hanging.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      scoreboard  = new();
      idle_enable = 1'b1;
      chars_sent  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;

      // Directed strings. The first walks through every result kind but the key
      // drop: a bare key cut by '=', a bare value cut by '=' (value done and key
      // done from one byte), the top byte value as a value byte, a bare value cut
      // by a quote that opens a quoted key holding the other quote, a blank before
      // '=', and a quoted value left open until the zero byte.
      directed_chars = '{"k", CHAR_EQUALS, "v", CHAR_EQUALS, 8'hFF, CHAR_SQUOTE,
                         CHAR_DQUOTE, CHAR_SQUOTE, CHAR_SPACE, CHAR_EQUALS,
                         CHAR_DQUOTE, CHAR_SQUOTE, CHAR_NUL,
                         // Bare key cut by a quote, tab kept inside the quotes,
                         // then the key dropped at the open end of the string.
                         "a", CHAR_SQUOTE, CHAR_TAB, CHAR_NUL,
                         // An empty key, then an empty value at the end.
                         CHAR_EQUALS, CHAR_NUL,
                         // A key with no '=' is dropped when the next one starts,
                         // and a pending key is dropped at the end of the string.
                         "x", CHAR_SPACE, CHAR_CR, "b", CHAR_LF, CHAR_NUL};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_chars[i])
         send_char(directed_chars[i]);

      while (chars_sent < TOTAL_CHARS) begin
         build_string();
         foreach (string_bytes[i]) begin
            // The closing stretch runs with no idling on either side.
            if (chars_sent >= CALM_FROM)
               idle_enable = 1'b0;
            send_char(string_bytes[i]);
         end
      end
      req_tvalid <= 1'b0;

      // Drain every expected token, then give the block time to show any extra.
      while (scoreboard.expected_tokens.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (scoreboard.errors == 0 && scoreboard.expected_tokens.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_parser.sv
rtl/core/kvt_out_buf.sv
rtl/core/key_value_init_string_tokenizer_core.sv
test/key_value_init_string_tokenizer_core_tb.sv
